[hdl/scr_pkg.sv]
// ----------------------------------------------------------------------------
// scr_pkg
// Shared widths, register indexes, reset values and types of the SCReLU
// output layer dot product block.
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int DATA_W      = 16;
    localparam int CLIP_W      = 8;
    localparam int SCALE_W     = 10;
    localparam int LIMIT_W     = 15;
    localparam int SUM_W       = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;

    // final arithmetic: |sum/qa + bias| * scale < 2^42
    localparam int DIV_DVD_W   = 42;
    localparam int DIV_DVS_W   = 16;
    localparam int E1_W        = 34;
    localparam int E2_W        = 43;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACT_CLIP    = 2'd0,
        CFG_OUT_QUANT   = 2'd1,
        CFG_EVAL_SCALE  = 2'd2,
        CFG_SCORE_LIMIT = 2'd3
    } t_cfg_idx;

    localparam logic [CLIP_W-1:0]  RST_ACT_CLIP    = 8'd255;
    localparam logic [CLIP_W-1:0]  RST_OUT_QUANT   = 8'd64;
    localparam logic [SCALE_W-1:0] RST_EVAL_SCALE  = 10'd400;
    localparam logic [LIMIT_W-1:0] RST_SCORE_LIMIT = 15'd31000;

    // lane pipeline tag that travels beside the lane payload
    typedef struct packed {
        logic valid;
        logic last;
    } t_pipe_ctl;

endpackage

[hdl/scr_lane.sv]
// ----------------------------------------------------------------------------
// scr_lane
// One SCReLU lane: clamp the accumulator to [0, qa], multiply by the weight,
// truncate the product to 16 bits, then multiply by the clamp again. Two stages.
// ----------------------------------------------------------------------------
module scr_lane (
    input  logic                                i_clk,
    input  logic signed [scr_pkg::DATA_W-1:0]   i_acc,
    input  logic signed [scr_pkg::DATA_W-1:0]   i_weight,
    input  logic        [scr_pkg::CLIP_W-1:0]   i_qa,
    output logic signed [scr_pkg::SUM_W-1:0]    o_term
);
    import scr_pkg::*;

    logic        [CLIP_W-1:0]          n_clip;
    logic        [CLIP_W-1:0]          r_clip;
    logic signed [DATA_W-1:0]          r_part;
    logic signed [CLIP_W+DATA_W:0]     w_prod1;
    logic signed [CLIP_W+DATA_W:0]     w_prod2;
    logic signed [SUM_W-1:0]           r_term;

    always_comb begin
        if (i_acc[DATA_W-1]) begin
            n_clip = '0;
        end else if (i_acc[DATA_W-2:0] > {{(DATA_W-1-CLIP_W){1'b0}}, i_qa}) begin
            n_clip = i_qa;
        end else begin
            n_clip = i_acc[CLIP_W-1:0];
        end
    end

    assign w_prod1 = $signed({{(DATA_W+1){1'b0}}, n_clip})
                   * $signed({{(CLIP_W+1){i_weight[DATA_W-1]}}, i_weight});
    assign w_prod2 = $signed({{(DATA_W+1){1'b0}}, r_clip})
                   * $signed({{(CLIP_W+1){r_part[DATA_W-1]}}, r_part});

    always_ff @(posedge i_clk) begin
        r_clip <= n_clip;
        r_part <= w_prod1[DATA_W-1:0];
        r_term <= {{(SUM_W-CLIP_W-DATA_W-1){w_prod2[CLIP_W+DATA_W]}}, w_prod2};
    end

    assign o_term = r_term;

endmodule

[hdl/scr_divider.sv]
// ----------------------------------------------------------------------------
// scr_divider
// Unsigned restoring divider, one quotient bit per cycle. Pulses o_done in the
// cycle after the last step; the quotient holds until the next start.
// ----------------------------------------------------------------------------
module scr_divider #(
    parameter int DVD_W = scr_pkg::DIV_DVD_W,
    parameter int DVS_W = scr_pkg::DIV_DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_run) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_run) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_diff[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/scr_merge.sv]
// ----------------------------------------------------------------------------
// scr_merge
// Merge stage: add both lane terms into the wrapping running sum, and on the
// last position run the final scaling (divide, bias, scale, divide, clamp)
// on a shared divider. Holds the score in an output register.
// ----------------------------------------------------------------------------
module scr_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scr_pkg::t_pipe_ctl                  i_ctl,
    input  logic signed [scr_pkg::SUM_W-1:0]    i_term_own,
    input  logic signed [scr_pkg::SUM_W-1:0]    i_term_opp,
    input  logic signed [scr_pkg::DATA_W-1:0]   i_bias,
    input  logic        [scr_pkg::CLIP_W-1:0]   i_qa,
    input  logic        [scr_pkg::CLIP_W-1:0]   i_qb,
    input  logic        [scr_pkg::SCALE_W-1:0]  i_scale,
    input  logic        [scr_pkg::LIMIT_W-1:0]  i_limit,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic signed [scr_pkg::DATA_W-1:0]   o_score,
    output logic                                o_done
);
    import scr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DIV1_GO = 7'b0000010,
        S_DIV1    = 7'b0000100,
        S_MUL     = 7'b0001000,
        S_DIV2_GO = 7'b0010000,
        S_DIV2    = 7'b0100000,
        S_CLAMP   = 7'b1000000
    } t_state;

    t_state                      r_state;
    logic        [SUM_W-1:0]     r_sum;
    logic        [SUM_W-1:0]     w_sum_next;
    logic                        r_neg;
    logic signed [E1_W-1:0]      r_e1;
    logic signed [E2_W-1:0]      r_e2;
    logic signed [E2_W-1:0]      r_e3;
    logic        [DIV_DVS_W-1:0] r_den;
    logic                        r_out_valid;
    logic signed [DATA_W-1:0]    r_score;

    logic                        w_div_start;
    logic        [DIV_DVD_W-1:0] w_dividend;
    logic        [DIV_DVS_W-1:0] w_divisor;
    logic                        w_div_done;
    logic        [DIV_DVD_W-1:0] w_quo;

    logic        [SUM_W:0]       w_sum_ext;
    logic        [SUM_W:0]       w_sum_abs;
    logic        [E2_W-1:0]      w_e2_abs;
    logic signed [SUM_W:0]       w_q1;
    logic signed [E1_W-1:0]      w_e1;
    logic signed [E1_W+SCALE_W:0] w_prod;
    logic signed [E2_W-1:0]      w_q2;
    logic signed [E2_W-1:0]      w_lim;
    logic signed [DATA_W-1:0]    w_clamped;
    logic                        w_load;

    assign w_sum_next = r_sum + i_term_own + i_term_opp;

    assign w_sum_ext = {r_sum[SUM_W-1], r_sum};
    assign w_sum_abs = r_sum[SUM_W-1] ? (~w_sum_ext + 1'b1) : w_sum_ext;
    assign w_e2_abs  = r_e2[E2_W-1] ? (~r_e2 + 1'b1) : r_e2;

    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = {{(DIV_DVD_W-SUM_W-1){1'b0}}, w_sum_abs};
        w_divisor   = {{(DIV_DVS_W-CLIP_W){1'b0}}, i_qa};
        case (r_state)
            S_DIV1_GO: begin
                w_div_start = 1'b1;
            end
            S_DIV2_GO: begin
                w_div_start = 1'b1;
                w_dividend  = w_e2_abs[DIV_DVD_W-1:0];
                w_divisor   = r_den;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    scr_divider #(
        .DVD_W (DIV_DVD_W),
        .DVS_W (DIV_DVS_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // restore the sign of each truncated quotient
    assign w_q1 = r_neg ? -$signed({1'b0, w_quo[SUM_W-1:0]})
                        :  $signed({1'b0, w_quo[SUM_W-1:0]});
    assign w_e1 = {w_q1[SUM_W], w_q1} + {{(E1_W-DATA_W){i_bias[DATA_W-1]}}, i_bias};
    assign w_prod = $signed({{(SCALE_W+1){r_e1[E1_W-1]}}, r_e1})
                  * $signed({{(E1_W+1){1'b0}}, i_scale});
    assign w_q2 = r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    assign w_lim = $signed({{(E2_W-LIMIT_W){1'b0}}, i_limit});

    always_comb begin
        if (r_e3 > w_lim) begin
            w_clamped = $signed({1'b0, i_limit});
        end else if (r_e3 < -w_lim) begin
            w_clamped = -$signed({1'b0, i_limit});
        end else begin
            w_clamped = r_e3[DATA_W-1:0];
        end
    end

    assign w_load = (r_state == S_CLAMP) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.valid) begin
                        r_sum <= w_sum_next;
                        if (i_ctl.last) begin
                            r_state <= S_DIV1_GO;
                        end
                    end
                end
                S_DIV1_GO: begin
                    r_sum   <= '0;
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV2_GO;
                end
                S_DIV2_GO: begin
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (w_div_done) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV1_GO) begin
            r_neg <= r_sum[SUM_W-1];
        end else if (r_state == S_DIV2_GO) begin
            r_neg <= r_e2[E2_W-1];
        end
        if (r_state == S_DIV1 && w_div_done) begin
            r_e1 <= w_e1;
        end
        if (r_state == S_MUL) begin
            r_e2  <= w_prod[E2_W-1:0];
            r_den <= DIV_DVS_W'(i_qa) * DIV_DVS_W'(i_qb);
        end
        if (r_state == S_DIV2 && w_div_done) begin
            r_e3 <= w_q2;
        end
        if (w_load) begin
            r_score <= w_clamped;
        end
    end

    assign o_valid = r_out_valid;
    assign o_score = r_score;
    assign o_done  = w_load;

endmodule

[hdl/screlu_output_layer_dot_unit.sv]
// ----------------------------------------------------------------------------
// screlu_output_layer_dot_unit
// SCReLU output layer dot product: two lanes (side to move, opponent) feed a
// merge stage that keeps the running sum and produces the clamped score.
//
//  channel   dir  handshake                  payload
//  s_axis    in   i_s_axis_tvalid/o_..tready  tdata[79:0] accs, weights, bias
//                                             tlast = last position
//  m_axis    out  o_m_axis_tvalid/i_..tready  tdata[15:0] score
//  cfg       in   i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// Positions without tlast are taken one per cycle while tready is high; the two
// lane stages are fully pipelined. A position with tlast holds tready low until
// its score is in the output register: lanes, merge, two passes of the shared
// divider at one quotient bit per cycle (42 steps each), scale and clamp. The
// score waits in an output register, so a stalled m_axis never blocks the next
// run until its own final scaling is done.
// Reset is synchronous: configuration registers return to defaults and the sum to zero.
// ----------------------------------------------------------------------------
module screlu_output_layer_dot_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // own_acc, opp_acc, own_weight, opp_weight, bucket_bias (lowest first)
    input  logic [scr_pkg::IN_TDATA_W-1:0]         i_s_axis_tdata,
    input  logic                                   i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // score
    output logic [scr_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    input  logic                                   i_cfg_we,
    input  logic [scr_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [scr_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);
    import scr_pkg::*;

    logic [CLIP_W-1:0]        r_act_clip;
    logic [CLIP_W-1:0]        r_out_quant;
    logic [SCALE_W-1:0]       r_eval_scale;
    logic [LIMIT_W-1:0]       r_score_limit;
    logic [CLIP_W-1:0]        w_qa;
    logic [CLIP_W-1:0]        w_qb;

    logic                     r_busy;
    logic                     w_accept;
    t_pipe_ctl                r_ctl1;
    t_pipe_ctl                r_ctl2;
    logic signed [DATA_W-1:0] r_bias;
    logic signed [SUM_W-1:0]  w_term_own;
    logic signed [SUM_W-1:0]  w_term_opp;
    logic signed [DATA_W-1:0] w_score;
    logic                     w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_clip    <= RST_ACT_CLIP;
            r_out_quant   <= RST_OUT_QUANT;
            r_eval_scale  <= RST_EVAL_SCALE;
            r_score_limit <= RST_SCORE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACT_CLIP:    r_act_clip    <= i_cfg_wdata[CLIP_W-1:0];
                CFG_OUT_QUANT:   r_out_quant   <= i_cfg_wdata[CLIP_W-1:0];
                CFG_EVAL_SCALE:  r_eval_scale  <= i_cfg_wdata[SCALE_W-1:0];
                CFG_SCORE_LIMIT: r_score_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a zero divisor setting acts as one
    assign w_qa = (r_act_clip == '0) ? CLIP_W'(1) : r_act_clip;
    assign w_qb = (r_out_quant == '0) ? CLIP_W'(1) : r_out_quant;

    assign o_s_axis_tready = !r_busy;
    assign w_accept        = i_s_axis_tvalid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1.valid <= w_accept;
            r_ctl1.last  <= w_accept && i_s_axis_tlast;
            r_ctl2       <= r_ctl1;
            // hold off new positions from a last transaction until its score is in the output register
            if (w_accept && i_s_axis_tlast) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_s_axis_tlast) begin
            r_bias <= i_s_axis_tdata[79:64];
        end
    end

    scr_lane u_lane_own (
        .i_clk    (i_clk),
        .i_acc    (i_s_axis_tdata[15:0]),
        .i_weight (i_s_axis_tdata[47:32]),
        .i_qa     (w_qa),
        .o_term   (w_term_own)
    );

    scr_lane u_lane_opp (
        .i_clk    (i_clk),
        .i_acc    (i_s_axis_tdata[31:16]),
        .i_weight (i_s_axis_tdata[63:48]),
        .i_qa     (w_qa),
        .o_term   (w_term_opp)
    );

    scr_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl2),
        .i_term_own (w_term_own),
        .i_term_opp (w_term_opp),
        .i_bias     (r_bias),
        .i_qa       (w_qa),
        .i_qb       (w_qb),
        .i_scale    (r_eval_scale),
        .i_limit    (r_score_limit),
        .i_ready    (i_m_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_score    (w_score),
        .o_done     (w_done)
    );

    assign o_m_axis_tdata = w_score;

`ifndef SYNTHESIS
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input accepted right after a last transaction");

    a_last_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl2.valid && r_ctl2.last) |-> r_busy)
        else $error("last position reached the merge stage while not busy");

    a_score_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_busy))
        else $error("score appeared without a pending run");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (o_s_axis_tready && o_m_axis_tvalid))
        else $error("finished score did not release the input side");
`endif

endmodule
